// File: hw/rtl/i2cmbe_pkg.sv
package i2cmbe_pkg;

    localparam int IN_W        = 16;
    localparam int OUT_W       = 16;
    localparam int HOLD_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd2;

    // raw mode codes on the input beat
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    // one classified tick as it sits in the queue
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

endpackage

// File: hw/rtl/i2cmbe_queue.sv
module i2cmbe_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hw/rtl/i2cmbe_front.sv
module i2cmbe_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [i2cmbe_pkg::IN_W-1:0]     s_tdata,
    output logic                            push_valid,
    input  logic                            push_ready,
    output i2cmbe_pkg::tick_t               push_tick
);

    logic [2:0] mode;

    assign mode       = s_tdata[2:0];
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

    always_comb
    begin
        push_tick.tx_byte  = s_tdata[10:3];
        push_tick.send_ack = s_tdata[11];
        push_tick.sda_in   = s_tdata[12];
        // unknown modes behave as a plain tick
        unique case (mode)
            i2cmbe_pkg::MODE_START: push_tick.cmd = i2cmbe_pkg::CMD_START;
            i2cmbe_pkg::MODE_STOP:  push_tick.cmd = i2cmbe_pkg::CMD_STOP;
            i2cmbe_pkg::MODE_WRITE: push_tick.cmd = i2cmbe_pkg::CMD_WRITE;
            i2cmbe_pkg::MODE_READ:  push_tick.cmd = i2cmbe_pkg::CMD_READ;
            default:                push_tick.cmd = i2cmbe_pkg::CMD_NONE;
        endcase
    end

endmodule

// File: hw/rtl/i2cmbe_back.sv
module i2cmbe_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [i2cmbe_pkg::HOLD_W-1:0]     cfg_wdata,
    input  logic                              tick_valid,
    output logic                              tick_ready,
    input  i2cmbe_pkg::tick_t                 tick,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2cmbe_pkg::OUT_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        OPN_IDLE,
        OPN_START,
        OPN_STOP,
        OPN_WRITE,
        OPN_READ_ACK,
        OPN_READ_NACK
    } op_t;

    typedef enum logic [2:0] {
        ACT_SDA0,
        ACT_SDA1,
        ACT_SCL0,
        ACT_SCL1,
        ACT_DLY,
        ACT_SDABIT,
        ACT_SDAACK,
        ACT_SCL0S
    } act_t;

    // line action at a given step of the current segment
    function automatic act_t seg_act(op_t op, logic trailer, logic [2:0] ph);
        act_t a;
        a = ACT_SDA1;
        unique case (op)
            OPN_START:
            begin
                unique case (ph)
                    3'd0:    a = ACT_SDA1;
                    3'd1:    a = ACT_SCL1;
                    3'd2:    a = ACT_SDA0;
                    3'd3:    a = ACT_DLY;
                    default: a = ACT_SCL0;
                endcase
            end
            OPN_STOP:
            begin
                unique case (ph)
                    3'd0:    a = ACT_SDA0;
                    3'd1:    a = ACT_SCL0;
                    3'd2:    a = ACT_SCL1;
                    3'd3:    a = ACT_DLY;
                    default: a = ACT_SDA1;
                endcase
            end
            OPN_WRITE:
            begin
                if (trailer)
                begin
                    unique case (ph)
                        3'd0:    a = ACT_SDA1;
                        3'd1:    a = ACT_DLY;
                        3'd2:    a = ACT_SCL1;
                        3'd3:    a = ACT_DLY;
                        3'd4:    a = ACT_SCL0S;
                        default: a = ACT_SCL0;
                    endcase
                end
                else
                begin
                    unique case (ph)
                        3'd0:    a = ACT_SDABIT;
                        3'd1:    a = ACT_SCL1;
                        3'd2:    a = ACT_DLY;
                        default: a = ACT_SCL0;
                    endcase
                end
            end
            OPN_READ_ACK, OPN_READ_NACK:
            begin
                unique case (ph)
                    3'd0:    a = trailer ? ACT_SDAACK : ACT_SDA1;
                    3'd1:    a = ACT_DLY;
                    3'd2:    a = ACT_SCL1;
                    3'd3:    a = ACT_DLY;
                    default: a = trailer ? ACT_SCL0 : ACT_SCL0S;
                endcase
            end
            default: a = ACT_SDA1;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] seg_last(op_t op, logic trailer);
        logic [2:0] l;
        unique case (op)
            OPN_WRITE: l = trailer ? 3'd5 : 3'd3;
            default:   l = 3'd4;
        endcase
        return l;
    endfunction

    op_t                          op_reg, op_next;
    logic [2:0]                   phase_reg, phase_next;
    logic [3:0]                   bit_reg, bit_next;
    logic [7:0]                   shift_reg, shift_next;
    logic [i2cmbe_pkg::HOLD_W-1:0] wait_reg, wait_next;
    logic [i2cmbe_pkg::HOLD_W-1:0] hold_reg;
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    logic                         ack_reg, ack_next;
    logic                         out_valid_reg, out_valid_next;
    logic [i2cmbe_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    op_t        op_c;
    logic [2:0] ph_c, ph_x, ph_adv;
    logic [3:0] bi_c;
    act_t       act_a, act_x;
    logic       busy, done, was_read, step;

    assign step       = tick_valid && (!out_valid_reg || m_tready);
    assign tick_ready = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_comb
    begin
        op_c       = op_reg;
        ph_c       = phase_reg;
        bi_c       = bit_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        busy       = 1'b0;
        done       = 1'b0;
        was_read   = 1'b0;
        ph_x       = ph_c;
        ph_adv     = ph_c;
        act_a      = ACT_SDA1;
        act_x      = ACT_SDA1;

        // a new command is taken only while idle
        if (op_reg == OPN_IDLE)
        begin
            ph_c = 3'd0;
            unique case (tick.cmd)
                i2cmbe_pkg::CMD_START:
                begin
                    op_c      = OPN_START;
                    bi_c      = 4'd8;
                    wait_next = '0;
                end
                i2cmbe_pkg::CMD_STOP:
                begin
                    op_c      = OPN_STOP;
                    bi_c      = 4'd8;
                    wait_next = '0;
                end
                i2cmbe_pkg::CMD_WRITE:
                begin
                    op_c       = OPN_WRITE;
                    bi_c       = 4'd0;
                    shift_next = tick.tx_byte;
                    wait_next  = '0;
                end
                i2cmbe_pkg::CMD_READ:
                begin
                    op_c       = tick.send_ack ? OPN_READ_ACK : OPN_READ_NACK;
                    bi_c       = 4'd0;
                    shift_next = '0;
                    wait_next  = '0;
                end
                default:
                begin
                    op_c = OPN_IDLE;
                    bi_c = bit_reg;
                end
            endcase
        end

        op_next    = op_c;
        phase_next = ph_c;
        bit_next   = bi_c;

        if (op_c != OPN_IDLE)
        begin
            busy     = 1'b1;
            was_read = (op_c == OPN_READ_ACK) || (op_c == OPN_READ_NACK);
            act_a    = seg_act(op_c, bi_c[3], ph_c);
            if (act_a == ACT_DLY && wait_next != '0)
            begin
                wait_next = wait_next - i2cmbe_pkg::HOLD_W'(1);
            end
            else
            begin
                // an expired delay falls through to the action behind it
                ph_x  = (act_a == ACT_DLY) ? ph_c + 3'd1 : ph_c;
                act_x = seg_act(op_c, bi_c[3], ph_x);
                unique case (act_x)
                    ACT_SDA0:   sda_next = 1'b0;
                    ACT_SDA1:   sda_next = 1'b1;
                    ACT_SCL0:   scl_next = 1'b0;
                    ACT_SCL1:   scl_next = 1'b1;
                    ACT_SDABIT: sda_next = shift_next[3'd7 - bi_c[2:0]];
                    ACT_SDAACK: sda_next = (op_c == OPN_READ_NACK);
                    ACT_SCL0S:
                    begin
                        if (bi_c[3])
                        begin
                            ack_next = tick.sda_in;
                        end
                        else
                        begin
                            shift_next = {shift_next[6:0], tick.sda_in};
                        end
                        scl_next = 1'b0;
                    end
                    default: ;
                endcase

                if (ph_x >= seg_last(op_c, bi_c[3]))
                begin
                    if (bi_c[3])
                    begin
                        op_next    = OPN_IDLE;
                        phase_next = 3'd0;
                        bit_next   = 4'd0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bi_c + 4'd1;
                        phase_next = 3'd0;
                    end
                end
                else
                begin
                    ph_adv     = ph_x + 3'd1;
                    phase_next = ph_adv;
                end

                if (!done && seg_act(op_c, bit_next[3], phase_next) == ACT_DLY)
                begin
                    wait_next = hold_reg;
                end
            end
        end

        out_valid_next = step || (out_valid_reg && !m_tready);
        out_data_next  = {3'b000, ack_next,
                          (done && was_read) ? shift_next : 8'h00,
                          done, busy, sda_next, scl_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OPN_IDLE;
            phase_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            hold_reg      <= i2cmbe_pkg::HOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hold_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                op_reg    <= op_next;
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                wait_reg  <= wait_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hw/rtl/i2c_master_bit_engine.sv
// I2C master line engine. Every input beat is one tick of bus time and yields
// exactly one output beat with the SCL/SDA drive levels (1 = released), busy,
// a done pulse, the received byte (on the done tick of a read, else 0) and the
// last write ACK. Commands (start, stop, write byte, read byte with ACK/NACK)
// are ignored while an operation runs; each delay holds the lines for
// hold_ticks ticks, set through cfg_we/cfg_wdata. The user must write it
// only while the engine is idle; the block itself does not enforce this.
// Throughput is one beat per clock while neither side stalls: the line
// sequencer does a whole tick at once, and a small queue in front of it and
// its output register, both of which each beat passes, let the sides stall independently.
module i2c_master_bit_engine #(
    parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] mode, [10:3] tx_byte, [11] send_ack, [12] sda_in
    input  logic [i2cmbe_pkg::IN_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_bit
    output logic [i2cmbe_pkg::OUT_W-1:0]      m_tdata,
    input  logic                              cfg_we,
    input  logic [i2cmbe_pkg::HOLD_W-1:0]     cfg_wdata
);

    localparam int TW = $bits(i2cmbe_pkg::tick_t);

    logic              push_valid, push_ready;
    i2cmbe_pkg::tick_t push_tick;
    logic              pop_valid, pop_ready;
    logic [TW-1:0]     pop_data;

    i2cmbe_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tick  (push_tick)
    );

    i2cmbe_queue #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_tick),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    i2cmbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .tick_valid (pop_valid),
        .tick_ready (pop_ready),
        .tick       (i2cmbe_pkg::tick_t'(pop_data)),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: hw/rtl/i2cmbe_checker.sv
module i2cmbe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [i2cmbe_pkg::OUT_W-1:0] m_tdata
);

    // done only ever marks a tick that executed a step
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("done beat without busy");

    // a received byte shows only on the done tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:4] != 8'h00) |-> m_tdata[3])
        else $error("rx_byte nonzero outside done");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
